// File: rtl/ptfr_pkg.sv
// Shared types and constants for the page translator with FIFO replacement.
// Holds controller/datapath command and status structs and the state enum.
// No dependencies.
package ptfr_pkg;

    localparam int OFFSET_BITS_DEF = 12;
    localparam int PAGE_COUNT_DEF  = 64;
    localparam int FRAME_COUNT_DEF = 8;

    localparam int ADDR_W     = 20;
    localparam int PHYS_W     = 15;
    localparam int VICTIM_W   = 6;
    localparam int CNT_W      = 32;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 96;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_VICTIM,
        ST_FILL,
        ST_RESULT
    } ptfr_state_t;

    typedef struct packed {
        logic accept;
        logic rd_req;
        logic hit_upd;
        logic load_free;
        logic load_evict;
        logic vict_upd;
        logic fill_new;
        logic publish;
        logic clr_step;
    } ptfr_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic bad;
        logic present;
        logic full;
        logic out_free;
    } ptfr_stat_t;

endpackage

// File: rtl/ptfr_ctrl.sv
// Sequencer for the page translator: clear sweep, lookup, load/evict, result.
// Depends on ptfr_pkg for the state enum and the command/status structs.
module ptfr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  ptfr_pkg::ptfr_stat_t stat,
    output ptfr_pkg::ptfr_cmd_t  cmd
);

    ptfr_pkg::ptfr_state_t state_reg;
    ptfr_pkg::ptfr_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ptfr_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ptfr_pkg::ST_CLEAR: begin
                if (stat.clr_last) state_next = ptfr_pkg::ST_IDLE;
            end
            ptfr_pkg::ST_IDLE: begin
                if (s_tvalid) state_next = ptfr_pkg::ST_READ;
            end
            ptfr_pkg::ST_READ: begin
                state_next = ptfr_pkg::ST_DECIDE;
            end
            ptfr_pkg::ST_DECIDE: begin
                if (stat.bad || stat.present || !stat.full) begin
                    state_next = ptfr_pkg::ST_RESULT;
                end else begin
                    state_next = ptfr_pkg::ST_VICTIM;
                end
            end
            ptfr_pkg::ST_VICTIM: begin
                state_next = ptfr_pkg::ST_FILL;
            end
            ptfr_pkg::ST_FILL: begin
                state_next = ptfr_pkg::ST_RESULT;
            end
            ptfr_pkg::ST_RESULT: begin
                if (stat.out_free) state_next = ptfr_pkg::ST_IDLE;
            end
            default: begin
                state_next = ptfr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ptfr_pkg::ST_CLEAR: begin
                cmd.clr_step = 1'b1;
            end
            ptfr_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ptfr_pkg::ST_READ: begin
                cmd.rd_req = 1'b1;
            end
            ptfr_pkg::ST_DECIDE: begin
                if (!stat.bad) begin
                    if (stat.present) begin
                        cmd.hit_upd = 1'b1;
                    end else if (!stat.full) begin
                        cmd.load_free = 1'b1;
                    end else begin
                        cmd.load_evict = 1'b1;
                    end
                end
            end
            ptfr_pkg::ST_VICTIM: begin
                cmd.vict_upd = 1'b1;
            end
            ptfr_pkg::ST_FILL: begin
                cmd.fill_new = 1'b1;
            end
            ptfr_pkg::ST_RESULT: begin
                cmd.publish = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/ptfr_datapath.sv
// Datapath of the page translator: page table memory, frame owner memory,
// fill count, replace pointer, counters and the result register.
// Depends on ptfr_pkg for widths and the command/status structs.
module ptfr_datapath #(
    parameter int OFFSET_BITS = ptfr_pkg::OFFSET_BITS_DEF,
    parameter int PAGE_COUNT  = ptfr_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = ptfr_pkg::FRAME_COUNT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [ptfr_pkg::ADDR_W-1:0]   s_address,
    input  logic                          s_write,
    input  ptfr_pkg::ptfr_cmd_t           cmd,
    output ptfr_pkg::ptfr_stat_t          stat,
    input  logic                          m_tready,
    output logic                          m_tvalid,
    output logic [ptfr_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int FRAME_W     = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
    localparam int FILL_W      = FRAME_W + 1;
    localparam int PFULL_W     = ptfr_pkg::ADDR_W - OFFSET_BITS;
    localparam int PCMP_W      = (PFULL_W > PAGE_W + 1) ? PFULL_W : PAGE_W + 1;
    localparam int ENT_W       = FRAME_W + 2;
    localparam int ENT_PRES    = FRAME_W + 1;
    localparam int ENT_DIRTY   = FRAME_W;
    localparam int PHYS_FULL_W = FRAME_W + OFFSET_BITS;
    localparam int PX_W        = (PHYS_FULL_W > ptfr_pkg::PHYS_W) ?
                                 PHYS_FULL_W : ptfr_pkg::PHYS_W;
    localparam int VX_W        = (PAGE_W > ptfr_pkg::VICTIM_W) ?
                                 PAGE_W : ptfr_pkg::VICTIM_W;
    localparam int DATA_BITS   = ptfr_pkg::PHYS_W + 4 + ptfr_pkg::VICTIM_W
                                 + 2 * ptfr_pkg::CNT_W;

    // Request latch
    logic [ptfr_pkg::ADDR_W-1:0] addr_reg;
    logic                        write_reg;

    // Page table: {present, dirty, frame}
    logic [ENT_W-1:0]  pt_mem [PAGE_COUNT];
    logic [ENT_W-1:0]  pt_rdata_reg;
    logic              pt_we;
    logic [PAGE_W-1:0] pt_waddr;
    logic [ENT_W-1:0]  pt_wdata;
    logic              pt_re;
    logic [PAGE_W-1:0] pt_raddr;

    // Frame owner table
    logic [PAGE_W-1:0]  own_mem [FRAME_COUNT];
    logic [PAGE_W-1:0]  own_rdata_reg;
    logic               own_we;
    logic [FRAME_W-1:0] own_waddr;

    logic [FILL_W-1:0]  fill_reg;
    logic [FRAME_W-1:0] rp_reg;
    logic [PAGE_W-1:0]  clr_idx_reg;

    logic [FRAME_W-1:0] frame_reg;
    logic               fault_reg;
    logic               evict_reg;
    logic [PAGE_W-1:0]  victim_reg;
    logic               wb_reg;

    // Result register
    logic                          m_tvalid_reg;
    logic [ptfr_pkg::PHYS_W-1:0]   phys_out_reg;
    logic                          bad_out_reg;
    logic                          fault_out_reg;
    logic                          evict_out_reg;
    logic [ptfr_pkg::VICTIM_W-1:0] victim_out_reg;
    logic                          wb_out_reg;
    logic [ptfr_pkg::CNT_W-1:0]    acc_cnt_reg;
    logic [ptfr_pkg::CNT_W-1:0]    flt_cnt_reg;

    logic [PCMP_W-1:0]      page_ext;
    logic                   bad;
    logic [PAGE_W-1:0]      page_idx;
    logic [FRAME_W-1:0]     fill_frame;
    logic [FRAME_W-1:0]     rp_adv;
    logic [PHYS_FULL_W-1:0] phys_full;
    logic [PX_W-1:0]        phys_ext;
    logic [VX_W-1:0]        victim_ext;

    assign page_ext   = PCMP_W'(addr_reg[ptfr_pkg::ADDR_W-1:OFFSET_BITS]);
    assign bad        = page_ext >= PCMP_W'(PAGE_COUNT);
    assign page_idx   = page_ext[PAGE_W-1:0];
    assign fill_frame = fill_reg[FRAME_W-1:0];
    assign rp_adv     = (rp_reg == FRAME_W'(FRAME_COUNT - 1)) ? '0 : rp_reg + 1'b1;
    assign phys_full  = {frame_reg, addr_reg[OFFSET_BITS-1:0]};
    assign phys_ext   = PX_W'(phys_full);
    assign victim_ext = VX_W'(victim_reg);

    assign stat.clr_last = clr_idx_reg == PAGE_W'(PAGE_COUNT - 1);
    assign stat.bad      = bad;
    assign stat.present  = pt_rdata_reg[ENT_PRES];
    assign stat.full     = fill_reg == FILL_W'(FRAME_COUNT);
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Page table write port
    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = page_idx;
        pt_wdata = {1'b1, write_reg, frame_reg};
        if (cmd.clr_step) begin
            pt_we    = 1'b1;
            pt_waddr = clr_idx_reg;
            pt_wdata = '0;
        end else if (cmd.hit_upd) begin
            pt_we    = 1'b1;
            pt_wdata = {1'b1, pt_rdata_reg[ENT_DIRTY] | write_reg,
                        pt_rdata_reg[FRAME_W-1:0]};
        end else if (cmd.load_free) begin
            pt_we    = 1'b1;
            pt_wdata = {1'b1, write_reg, fill_frame};
        end else if (cmd.vict_upd) begin
            // Drop residency, keep the dirty bit and frame as they were.
            pt_we    = 1'b1;
            pt_waddr = victim_reg;
            pt_wdata = {1'b0, pt_rdata_reg[ENT_DIRTY:0]};
        end else if (cmd.fill_new) begin
            pt_we    = 1'b1;
        end
    end

    assign pt_re    = cmd.rd_req || cmd.load_evict;
    assign pt_raddr = cmd.load_evict ? own_rdata_reg : page_idx;

    always_ff @(posedge aclk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (pt_re) begin
            pt_rdata_reg <= pt_mem[pt_raddr];
        end
    end

    assign own_we    = cmd.load_free || cmd.load_evict;
    assign own_waddr = cmd.load_free ? fill_frame : rp_reg;

    always_ff @(posedge aclk) begin
        if (own_we) begin
            own_mem[own_waddr] <= page_idx;
        end
        if (cmd.rd_req) begin
            own_rdata_reg <= own_mem[rp_reg];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            rp_reg       <= '0;
            clr_idx_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            acc_cnt_reg  <= '0;
            flt_cnt_reg  <= '0;
        end else begin
            if (cmd.clr_step) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.load_free) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.load_evict) begin
                rp_reg <= rp_adv;
            end
            if (cmd.publish) begin
                m_tvalid_reg <= 1'b1;
                acc_cnt_reg  <= acc_cnt_reg + 1'b1;
                flt_cnt_reg  <= flt_cnt_reg + ptfr_pkg::CNT_W'(fault_reg);
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Per-item payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            addr_reg  <= s_address;
            write_reg <= s_write;
            fault_reg <= 1'b0;
            evict_reg <= 1'b0;
            wb_reg    <= 1'b0;
            frame_reg <= '0;
        end
        if (cmd.hit_upd) begin
            frame_reg <= pt_rdata_reg[FRAME_W-1:0];
        end
        if (cmd.load_free) begin
            frame_reg <= fill_frame;
            fault_reg <= 1'b1;
        end
        if (cmd.load_evict) begin
            frame_reg  <= rp_reg;
            fault_reg  <= 1'b1;
            evict_reg  <= 1'b1;
            victim_reg <= own_rdata_reg;
        end
        if (cmd.vict_upd) begin
            wb_reg <= pt_rdata_reg[ENT_DIRTY];
        end
        if (cmd.publish) begin
            phys_out_reg   <= bad ? '0 : phys_ext[ptfr_pkg::PHYS_W-1:0];
            bad_out_reg    <= bad;
            fault_out_reg  <= fault_reg;
            evict_out_reg  <= evict_reg;
            victim_out_reg <= evict_reg ? victim_ext[ptfr_pkg::VICTIM_W-1:0] : '0;
            wb_out_reg     <= wb_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(ptfr_pkg::M_TDATA_W - DATA_BITS){1'b0}},
                       flt_cnt_reg, acc_cnt_reg, wb_out_reg, victim_out_reg,
                       evict_out_reg, fault_out_reg, bad_out_reg, phys_out_reg};

endmodule

// File: rtl/page_translate_fifo_replace.sv
// Top level of the demand-paging address translator with FIFO replacement.
// Instantiates ptfr_ctrl and ptfr_datapath; depends on ptfr_pkg.
//
// Translates one logical byte address per transfer into a physical address.
// After reset the block sweeps the page table, one entry per cycle, before
// it raises s_tready. A transfer then passes through the read and decide
// steps to the result step on a hit, a bad page or a fault into a free
// frame, and through the victim and fill steps as well when a resident page
// must be evicted; a new transfer is accepted only once the block is back
// in its idle step. The page table memory, with one write port and a
// registered read, sets these extra steps, since an eviction needs a second
// read of the victim's entry and two separate writes. A result that the
// receiver has not yet taken holds the block in its result step. A finished
// result sits in the output register while the next transfer is accepted.
// Free frames are taken in index order; once all are in use a round-robin
// pointer picks the victim, which is first-in-first-out order because
// frames are never released.
module page_translate_fifo_replace #(
    parameter int OFFSET_BITS = ptfr_pkg::OFFSET_BITS_DEF,
    parameter int PAGE_COUNT  = ptfr_pkg::PAGE_COUNT_DEF,
    parameter int FRAME_COUNT = ptfr_pkg::FRAME_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [19:0] logical_address, [23:20] zero
    input  logic [ptfr_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] command (1 = write)
    input  logic                           s_tuser,
    // Result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [14:0] physical_address, [15] bad_page, [16] page_fault, [17] evicted,
    // [23:18] evicted page number, [24] write_back, [56:25] access_total,
    // [88:57] fault_total, [95:89] zero
    output logic [ptfr_pkg::M_TDATA_W-1:0] m_tdata
);

    ptfr_pkg::ptfr_cmd_t  cmd;
    ptfr_pkg::ptfr_stat_t stat;

    // Sequence each transfer through lookup, load or evict, and result.
    ptfr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the tables, pointers and counters; drive the result register.
    ptfr_datapath #(
        .OFFSET_BITS (OFFSET_BITS),
        .PAGE_COUNT  (PAGE_COUNT),
        .FRAME_COUNT (FRAME_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_address (s_tdata[ptfr_pkg::ADDR_W-1:0]),
        .s_write   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule
